// ===== rtl/serb_pkg.sv =====
// ---------------------------------------------------------------------------
// serb_pkg
// Shared types and codes of the sequenced event replay buffer.
// ---------------------------------------------------------------------------
package serb_pkg;

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_REPLAY = 2'd1;
    localparam logic [1:0] OP_RESET  = 2'd2;

    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_BAD_LIMIT = 4'd1;
    localparam logic [3:0] ST_BAD_EVENT = 4'd2;
    localparam logic [3:0] ST_TOO_LARGE = 4'd3;
    localparam logic [3:0] ST_GAP       = 4'd4;
    localparam logic [3:0] ST_FUTURE    = 4'd5;
    localparam logic [3:0] ST_CURRENT   = 4'd6;
    localparam logic [3:0] ST_SNAPSHOT  = 4'd7;
    localparam logic [3:0] ST_REPLAYING = 4'd8;

    localparam logic REG_MAX_COUNT = 1'b0;
    localparam logic REG_MAX_BYTES = 1'b1;

    localparam logic [63:0] SEQ_ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [63:0] sequence_number;
        logic [15:0] event_size;
        logic [63:0] event_payload;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [63:0] replay_sequence;
        logic [63:0] replay_payload;
        logic        last_result;
        logic [5:0]  stored_count;
        logic [15:0] stored_bytes;
        logic [63:0] oldest_held_sequence;
        logic [63:0] newest_sequence;
    } out_item_t;

endpackage

// ===== rtl/serb_front.sv =====
// ---------------------------------------------------------------------------
// serb_front
// Accepts requests, drops unknown opcodes, trims the size field and queues
// the rest in a two-entry queue for the back end.
// ---------------------------------------------------------------------------
module serb_front #(
    parameter int SIZE_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  serb_pkg::in_item_t in_data,
    output logic               cmd_valid,
    output serb_pkg::in_item_t cmd,
    input  logic               cmd_take
);
    import serb_pkg::*;

    localparam int SZ_W = (SIZE_BITS < 16) ? SIZE_BITS : 16;
    localparam logic [15:0] SIZE_MASK = 16'((17'd1 << SZ_W) - 17'd1);

    in_item_t   q_mem [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] fill_reg;
    logic       push, pop;
    in_item_t   item;

    assign in_stall  = (fill_reg == 2'd2);
    assign cmd_valid = (fill_reg != 2'd0);
    assign cmd       = q_mem[rd_ptr_reg];
    assign pop       = cmd_valid && cmd_take;

    always_comb
    begin
        item            = in_data;
        item.event_size = in_data.event_size & SIZE_MASK;
        push = in_valid && !in_stall && (in_data.opcode == OP_APPEND ||
               in_data.opcode == OP_REPLAY || in_data.opcode == OP_RESET);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            fill_reg <= fill_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

// ===== rtl/serb_back.sv =====
// ---------------------------------------------------------------------------
// serb_back
// Executes queued requests against the event ring: appends with eviction,
// replays one event at a time, and holds the result output register.
// ---------------------------------------------------------------------------
module serb_back #(
    parameter int RING_DEPTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [15:0]         cfg_wdata,
    input  logic                cmd_valid,
    input  serb_pkg::in_item_t  cmd,
    output logic                cmd_take,
    output logic                out_valid,
    input  logic                out_stall,
    output serb_pkg::out_item_t out_data
);
    import serb_pkg::*;

    localparam int IW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(RING_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE     = 4'b0001,
        S_EVICT    = 4'b0010,
        S_REP_RD   = 4'b0100,
        S_REP_EMIT = 4'b1000
    } state_t;

    state_t        state_reg, state_next;
    logic [IW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [16:0]   bytes_reg, bytes_next;
    logic [63:0]   oldest_reg, oldest_next;
    logic [63:0]   latest_reg, latest_next;
    logic [5:0]    max_count_reg;
    logic [15:0]   max_bytes_reg;
    logic [63:0]   cur_seq_reg, cur_seq_next;
    logic [IW-1:0] rd_ptr_reg, rd_ptr_next;
    logic          out_valid_reg, out_valid_next;
    out_item_t     out_data_reg, out_data_next;

    logic [15:0]   size_mem [RING_DEPTH];
    logic [63:0]   pay_mem  [RING_DEPTH];
    logic [15:0]   head_size_reg;
    logic [63:0]   pay_rd_reg;

    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic          out_free;
    logic [7:0]    limit;
    logic          need_evict;
    logic          full;
    logic [3:0]    app_status;
    logic [3:0]    rep_status;
    logic [63:0]   seq_p1;
    logic [63:0]   off_wide;

    function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] a,
                                               input logic [CW-1:0] b);
        logic [CW:0] s;
        s = (CW+1)'(a) + (CW+1)'(b);
        if (s >= (CW+1)'(RING_DEPTH))
        begin
            s = s - (CW+1)'(RING_DEPTH);
        end
        return IW'(s);
    endfunction

    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        limit = (8'(max_count_reg) > 8'(RING_DEPTH)) ? 8'(RING_DEPTH)
                                                     : 8'(max_count_reg);
        need_evict = (8'(count_reg) > limit) || (bytes_reg > 17'(max_bytes_reg));
        full   = (count_reg == DEPTH_C);
        seq_p1 = cmd.sequence_number + 64'd1;
        off_wide = seq_p1 - oldest_reg;

        if (limit == 8'd0 || max_bytes_reg == 16'd0)
            app_status = ST_BAD_LIMIT;
        else if (cmd.event_size == 16'd0)
            app_status = ST_BAD_EVENT;
        else if (cmd.event_size > max_bytes_reg)
            app_status = ST_TOO_LARGE;
        else if (latest_reg == SEQ_ALL_ONES || cmd.sequence_number != latest_reg + 64'd1)
            app_status = ST_GAP;
        else
            app_status = ST_OK;

        if (cmd.sequence_number > latest_reg)
            rep_status = ST_FUTURE;
        else if (cmd.sequence_number == latest_reg)
            rep_status = ST_CURRENT;
        else if (count_reg == '0 || cmd.sequence_number == SEQ_ALL_ONES ||
                 seq_p1 < oldest_reg)
            rep_status = ST_SNAPSHOT;
        else
            rep_status = ST_REPLAYING;
    end

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        bytes_next     = bytes_reg;
        oldest_next    = oldest_reg;
        latest_next    = latest_reg;
        cur_seq_next   = cur_seq_reg;
        rd_ptr_next    = rd_ptr_reg;
        cmd_take       = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = head_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;

        out_data_next.status               = ST_OK;
        out_data_next.replay_sequence      = '0;
        out_data_next.replay_payload       = '0;
        out_data_next.last_result          = 1'b1;
        out_data_next.stored_count         = 6'(count_reg);
        out_data_next.stored_bytes         = bytes_reg[15:0];
        out_data_next.oldest_held_sequence = (count_reg != '0) ? oldest_reg : '0;
        out_data_next.newest_sequence      = latest_reg;
        if (!out_free)
        begin
            out_data_next = out_data_reg;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.opcode)
                        OP_APPEND:
                        begin
                            if (app_status != ST_OK)
                            begin
                                if (out_free)
                                begin
                                    cmd_take             = 1'b1;
                                    out_valid_next       = 1'b1;
                                    out_data_next.status = app_status;
                                end
                            end
                            else
                            begin
                                cmd_take    = 1'b1;
                                wr_en       = 1'b1;
                                latest_next = cmd.sequence_number;
                                if (full)
                                begin
                                    // Ring full: the oldest slot is reused.
                                    wr_addr     = head_reg;
                                    head_next   = wrap_add(head_reg, CW'(1));
                                    bytes_next  = bytes_reg - 17'(head_size_reg)
                                                  + 17'(cmd.event_size);
                                    oldest_next = oldest_reg + 64'd1;
                                end
                                else
                                begin
                                    wr_addr     = wrap_add(head_reg, count_reg);
                                    count_next  = count_reg + CW'(1);
                                    bytes_next  = bytes_reg + 17'(cmd.event_size);
                                    if (count_reg == '0)
                                    begin
                                        oldest_next = cmd.sequence_number;
                                    end
                                end
                                state_next = S_EVICT;
                            end
                        end
                        OP_REPLAY:
                        begin
                            if (rep_status != ST_REPLAYING)
                            begin
                                if (out_free)
                                begin
                                    cmd_take             = 1'b1;
                                    out_valid_next       = 1'b1;
                                    out_data_next.status = rep_status;
                                end
                            end
                            else
                            begin
                                cmd_take     = 1'b1;
                                cur_seq_next = seq_p1;
                                rd_ptr_next  = wrap_add(head_reg, CW'(off_wide));
                                state_next   = S_REP_RD;
                            end
                        end
                        OP_RESET:
                        begin
                            if (out_free)
                            begin
                                cmd_take    = 1'b1;
                                head_next   = '0;
                                count_next  = '0;
                                bytes_next  = '0;
                                latest_next = cmd.sequence_number;
                                out_valid_next                     = 1'b1;
                                out_data_next.stored_count         = '0;
                                out_data_next.stored_bytes         = '0;
                                out_data_next.oldest_held_sequence = '0;
                                out_data_next.newest_sequence      = cmd.sequence_number;
                            end
                        end
                        default:
                        begin
                            cmd_take = 1'b1;
                        end
                    endcase
                end
            end
            S_EVICT:
            begin
                if (need_evict)
                begin
                    head_next   = wrap_add(head_reg, CW'(1));
                    count_next  = count_reg - CW'(1);
                    bytes_next  = bytes_reg - 17'(head_size_reg);
                    oldest_next = oldest_reg + 64'd1;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_REP_RD:
            begin
                state_next = S_REP_EMIT;
            end
            S_REP_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next                = 1'b1;
                    out_data_next.status          = ST_REPLAYING;
                    out_data_next.replay_sequence = cur_seq_reg;
                    out_data_next.replay_payload  = pay_rd_reg;
                    out_data_next.last_result     = (cur_seq_reg == latest_reg);
                    if (cur_seq_reg == latest_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cur_seq_next = cur_seq_reg + 64'd1;
                        rd_ptr_next  = wrap_add(rd_ptr_reg, CW'(1));
                        state_next   = S_REP_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Ring memories; the size at the head is kept in a registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            size_mem[wr_addr] <= cmd.event_size;
            pay_mem[wr_addr]  <= cmd.event_payload;
        end
        if (wr_en && wr_addr == head_next)
        begin
            head_size_reg <= cmd.event_size;
        end
        else
        begin
            head_size_reg <= size_mem[head_next];
        end
        pay_rd_reg <= pay_mem[rd_ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        cur_seq_reg  <= cur_seq_next;
        rd_ptr_reg   <= rd_ptr_next;
        oldest_reg   <= oldest_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            bytes_reg     <= '0;
            latest_reg    <= '0;
            out_valid_reg <= 1'b0;
            max_count_reg <= 6'd32;
            max_bytes_reg <= 16'd4096;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            bytes_reg     <= bytes_next;
            latest_reg    <= latest_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MAX_COUNT: max_count_reg <= cfg_wdata[5:0];
                    REG_MAX_BYTES: max_bytes_reg <= cfg_wdata;
                    default:       max_bytes_reg <= max_bytes_reg;
                endcase
            end
        end
    end

endmodule

// ===== rtl/sequenced_event_replay_buffer.sv =====
// ---------------------------------------------------------------------------
// sequenced_event_replay_buffer
// Bounded ring of sequenced events with append, replay and reset requests.
// ---------------------------------------------------------------------------
// Usage. Requests arrive on the in_valid/in_stall/in_data channel; a transfer
// happens on a rising edge with in_valid high and in_stall low. Results leave
// on out_valid/out_stall/out_data the same way. max_event_count (index 0) and
// max_total_bytes (index 1) are written through cfg_we/cfg_index/cfg_wdata
// while the block is idle.
// Request flow. A request enters a two-entry queue in the front end and,
// with the queue empty, the back end sees it in the cycle after the transfer.
// Resets and rejected requests set out_valid through the output register when
// the back end takes them; an accepted append first enters the evict state,
// drops the oldest entries there while a limit is exceeded, and then raises
// out_valid. A replay reads each payload with a registered read, emits it from
// the emit state, then reads the next. Unknown opcodes are dropped silently.
// Reset clears the ring to empty, sets the latest sequence to zero and loads
// the limits to 32 events and 4096 bytes. No clearing pass is needed. When
// the receiver stalls, the result is held in the output register, the back
// end waits, and the queue fills before in_stall is raised.
// ---------------------------------------------------------------------------
module sequenced_event_replay_buffer #(
    parameter int RING_DEPTH = 32,
    parameter int SIZE_BITS  = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  serb_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output serb_pkg::out_item_t out_data,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [15:0]         cfg_wdata
);
    import serb_pkg::*;

    // Classified request travelling from the front end to the back end.
    logic     cmd_valid;
    logic     cmd_take;
    in_item_t cmd;

    serb_front #(
        .SIZE_BITS(SIZE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    serb_back #(
        .RING_DEPTH(RING_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ===== rtl/serb_checker.sv =====
// ---------------------------------------------------------------------------
// serb_port_checks
// Port-level checks of the replay buffer, bound to the top level.
// ---------------------------------------------------------------------------
module serb_port_checks (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_stall,
    input serb_pkg::out_item_t out_data
);
    import serb_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result withdrawn while stalled");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_REPLAYING |-> out_data.last_result)
        else $error("non-replay result without last marker");

    a_empty_oldest: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.stored_count == 6'd0 |->
            out_data.oldest_held_sequence == 64'd0)
        else $error("empty ring reports an oldest sequence");

    a_no_replay_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_REPLAYING |->
            out_data.replay_sequence == 64'd0 && out_data.replay_payload == 64'd0)
        else $error("replay fields set on a non-replay result");

endmodule

bind sequenced_event_replay_buffer serb_port_checks u_serb_port_checks (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
